// ===== rtl/core/cross_median_filter_macros.svh =====
// Assertion macros shared by the checker of the cross median filter.
`ifndef CROSS_MEDIAN_FILTER_MACROS_SVH
`define CROSS_MEDIAN_FILTER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CMF_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cross median filter: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CMF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cross median filter: assertion failed");

// The consequent must hold in the cycle after reset is high.
`define CMF_ASSERT_AFTER_RESET(label, clk, rst, cons) \
  label: assert property (@(posedge clk) (rst) |=> (cons)) \
    else $error("cross median filter: assertion failed");

`endif

// ===== rtl/core/cmf_pkg.sv =====
// Shared constants and types of the cross median filter.
package cmf_pkg;

  localparam int MAX_WIDTH  = 512;
  localparam int MAX_RADIUS = 5;

  localparam int PIXEL_W     = 8;
  localparam int CFG_DATA_W  = 10;
  localparam int CFG_INDEX_W = 2;
  localparam int ROW_W       = 10;
  localparam int RAD_W       = 3;

  localparam logic [CFG_INDEX_W-1:0] IDX_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] IDX_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] IDX_RADIUS = 2'd2;

  localparam logic [CFG_DATA_W-1:0] RESET_WIDTH  = 10'd256;
  localparam logic [CFG_DATA_W-1:0] RESET_HEIGHT = 10'd256;
  localparam logic [RAD_W-1:0]      RESET_RADIUS = 3'd2;

  localparam logic OP_PAD = 1'b1;

  typedef struct packed {
    logic valid;
    logic emit;
    logic frame_end;
  } cmf_ctl_t;

endpackage

// ===== rtl/core/cmf_if.sv =====
// Handshake interfaces for the pixel, median and configuration channels.
interface cmf_pixel_if;
  logic                        valid;
  logic                        ready;
  logic                        operation;
  logic [cmf_pkg::PIXEL_W-1:0] pixel;
  modport source (output valid, output operation, output pixel, input ready);
  modport sink (input valid, input operation, input pixel, output ready);
endinterface

interface cmf_median_if;
  logic                        valid;
  logic                        ready;
  logic [cmf_pkg::PIXEL_W-1:0] median_value;
  logic                        frame_end;
  modport source (output valid, output median_value, output frame_end, input ready);
  modport sink (input valid, input median_value, input frame_end, output ready);
endinterface

interface cmf_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [cmf_pkg::CFG_INDEX_W-1:0] index;
  logic [cmf_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/cmf_rank_select.sv =====
// Two-stage rank computation and selection of the median of the cross window.
module cmf_rank_select #(
  parameter int MAX_RADIUS = cmf_pkg::MAX_RADIUS
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        en,
  input  cmf_pkg::cmf_ctl_t                           in_ctl,
  input  logic [4*MAX_RADIUS+1:0][cmf_pkg::PIXEL_W-1:0] in_vals,
  input  logic [cmf_pkg::RAD_W-1:0]                   radius,
  output cmf_pkg::cmf_ctl_t                           out_ctl,
  output logic [cmf_pkg::PIXEL_W-1:0]                 median
);

  localparam int VN     = 4 * MAX_RADIUS + 2;
  localparam int RANK_W = $clog2(VN);

  cmf_pkg::cmf_ctl_t                       a_ctl;
  logic [VN-1:0][cmf_pkg::PIXEL_W-1:0]     a_vals;
  logic [cmf_pkg::RAD_W-1:0]               a_rad;
  cmf_pkg::cmf_ctl_t                       b_ctl;
  logic [VN-1:0][cmf_pkg::PIXEL_W-1:0]     b_vals;
  logic [VN-1:0][RANK_W-1:0]               b_rank;
  logic [cmf_pkg::RAD_W-1:0]               b_rad;
  logic [VN-1:0][RANK_W-1:0]               rank_next;
  logic [RANK_W-1:0]                       target;

  // Rank of each value: smaller values plus equal ones earlier in the list.
  always_comb begin
    logic [VN-1:0] lower;
    for (int i = 0; i < VN; i++) begin
      for (int j = 0; j < VN; j++) begin
        lower[j] = (j != i) && ((a_vals[j] < a_vals[i]) ||
                                ((a_vals[j] == a_vals[i]) && (j < i)));
      end
      rank_next[i] = RANK_W'($countones(lower));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_ctl <= '0;
      b_ctl <= '0;
    end else if (en) begin
      a_ctl <= in_ctl;
      b_ctl <= a_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_vals <= in_vals;
      a_rad  <= radius;
      b_vals <= a_vals;
      b_rank <= rank_next;
      b_rad  <= a_rad;
    end
  end

  assign target = RANK_W'({b_rad, 1'b0});

  always_comb begin
    median = '0;
    for (int i = 0; i < VN; i++) begin
      if (b_rank[i] == target) begin
        median = b_vals[i];
      end
    end
  end

  assign out_ctl = b_ctl;

endmodule

// ===== rtl/core/cross_median_filter.sv =====
// Top level of the cross median filter with line memory and output skid.
// A result passes the stage-1 registers, both rank-select stages and the output register.
// Throughput: one word per cycle while the skid is empty; the single-port-read line memory is read once per word.
// A stalled output parks one result in a skid register before input is held off.
// Reset clears the counters, the pipeline valids and loads the register defaults.
// The line memory is not cleared; each entry is written before it is read.
module cross_median_filter #(
  parameter int MAX_WIDTH  = cmf_pkg::MAX_WIDTH,
  parameter int MAX_RADIUS = cmf_pkg::MAX_RADIUS
) (
  input logic          clk,
  input logic          rst,
  cmf_cfg_if.sink      cfg,
  cmf_pixel_if.sink    pixels,
  cmf_median_if.source medians
);

  localparam int SLOTS      = 2 * MAX_RADIUS;
  localparam int LINE_LEN   = MAX_WIDTH + MAX_RADIUS;
  localparam int CW         = $clog2(LINE_LEN);
  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int VN         = 4 * MAX_RADIUS + 2;
  localparam int TAPS       = 2 * MAX_RADIUS + 1;
  localparam int HEIGHT_CAP = (2 ** cmf_pkg::ROW_W) - 1 - MAX_RADIUS;
  localparam int PW         = cmf_pkg::PIXEL_W;
  localparam int RW         = cmf_pkg::ROW_W;

  logic [cmf_pkg::CFG_DATA_W-1:0] width_q;
  logic [cmf_pkg::CFG_DATA_W-1:0] height_q;
  logic [cmf_pkg::RAD_W-1:0]      radius_q;
  logic [CW-1:0]                  w_eff;
  logic [RW-1:0]                  h_eff;
  logic [cmf_pkg::RAD_W-1:0]      r_eff;

  logic [RW-1:0]     row;
  logic [CW-1:0]     col;
  logic [SLOT_W-1:0] rslot;
  logic [RW-1:0]     row_next;
  logic [CW-1:0]     col_next;
  logic [SLOT_W-1:0] rslot_next;

  logic                en;
  logic                accept;
  logic [PW-1:0]       value;
  logic [PW-1:0]       win [MAX_RADIUS];
  logic [PW-1:0]       center;
  logic                emit;
  logic                frame_end;
  logic                center_ok;
  logic                we;
  logic [CW-1:0]       waddr;

  logic [SLOTS-1:0][PW-1:0] line_mem [LINE_LEN];
  logic [SLOTS-1:0][PW-1:0] mem_q;

  cmf_pkg::cmf_ctl_t   s1_ctl;
  logic [RW-1:0]       s1_row;
  logic [CW-1:0]       s1_col;
  logic [SLOT_W-1:0]   s1_rslot;
  logic [PW-1:0]       s1_center;

  logic [SLOTS-1:0][PW-1:0] vline [MAX_RADIUS];
  logic [PW-1:0]            hline [2*MAX_RADIUS];
  logic [PW-1:0]            hbyte;
  logic [VN-1:0][PW-1:0]    s1_vals;

  cmf_pkg::cmf_ctl_t   b_ctl;
  logic [PW-1:0]       b_median;
  logic                new_res;

  logic                out_valid;
  logic [PW-1:0]       out_median;
  logic                out_frame_end;
  logic                skid_valid;
  logic [PW-1:0]       skid_median;
  logic                skid_frame_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_q  <= cmf_pkg::RESET_WIDTH;
      height_q <= cmf_pkg::RESET_HEIGHT;
      radius_q <= cmf_pkg::RESET_RADIUS;
    end else if (cfg.valid) begin
      case (cfg.index)
        cmf_pkg::IDX_WIDTH:  width_q  <= cfg.data;
        cmf_pkg::IDX_HEIGHT: height_q <= cfg.data;
        cmf_pkg::IDX_RADIUS: radius_q <= cfg.data[cmf_pkg::RAD_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.ready = 1'b1;

  always_comb begin
    if (width_q == '0) begin
      w_eff = CW'(1);
    end else if (int'(width_q) > MAX_WIDTH) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = CW'(width_q);
    end
    if (height_q == '0) begin
      h_eff = RW'(1);
    end else if (int'(height_q) > HEIGHT_CAP) begin
      h_eff = RW'(HEIGHT_CAP);
    end else begin
      h_eff = RW'(height_q);
    end
    if (radius_q == '0) begin
      r_eff = cmf_pkg::RAD_W'(1);
    end else if (int'(radius_q) > MAX_RADIUS) begin
      r_eff = cmf_pkg::RAD_W'(MAX_RADIUS);
    end else begin
      r_eff = radius_q;
    end
  end

  assign en            = !skid_valid;
  assign pixels.ready  = en;
  assign accept        = pixels.valid && en;
  assign value         = (pixels.operation == cmf_pkg::OP_PAD) ? '0 : pixels.pixel;

  // The word from R positions back becomes the center after this shift.
  always_comb begin
    center = '0;
    for (int k = 0; k < MAX_RADIUS; k++) begin
      if (k == int'(r_eff) - 1) begin
        center = win[k];
      end
    end
  end

  assign emit      = (int'(row) >= int'(r_eff)) && (int'(col) >= int'(r_eff));
  assign frame_end = (int'(row) == int'(h_eff) + int'(r_eff) - 1) &&
                     (int'(col) == int'(w_eff) + int'(r_eff) - 1);
  assign center_ok = (int'(row) < int'(h_eff)) &&
                     (int'(col) - int'(r_eff) < int'(w_eff));
  assign we        = accept && (int'(col) >= int'(r_eff)) &&
                     (int'(col) - int'(r_eff) < int'(w_eff));
  assign waddr     = CW'(int'(col) - int'(r_eff));

  always_comb begin
    row_next   = row;
    col_next   = col;
    rslot_next = rslot;
    if (int'(col) + 1 >= int'(w_eff) + int'(r_eff)) begin
      col_next   = '0;
      row_next   = RW'(int'(row) + 1);
      rslot_next = (int'(rslot) == SLOTS - 1) ? '0 : SLOT_W'(int'(rslot) + 1);
    end else begin
      col_next = CW'(int'(col) + 1);
    end
    if (int'(row_next) >= int'(h_eff) + int'(r_eff)) begin
      row_next   = '0;
      rslot_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row    <= '0;
      col    <= '0;
      rslot  <= '0;
      s1_ctl <= '0;
    end else if (en) begin
      if (accept) begin
        row   <= row_next;
        col   <= col_next;
        rslot <= rslot_next;
      end
      s1_ctl.valid     <= accept;
      s1_ctl.emit      <= emit;
      s1_ctl.frame_end <= frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      win[0] <= value;
      for (int k = 1; k < MAX_RADIUS; k++) begin
        win[k] <= win[k-1];
      end
      s1_row    <= row;
      s1_col    <= col;
      s1_rslot  <= rslot;
      s1_center <= center_ok ? center : '0;
    end
  end

  // Line memory: one address per column, one byte lane per buffered row.
  always_ff @(posedge clk) begin
    if (we) begin
      line_mem[waddr][rslot] <= center;
    end
    if (accept) begin
      mem_q <= line_mem[col];
    end
  end

  always_comb begin
    int hs;
    hs = int'(s1_rslot) - int'(r_eff);
    if (hs < 0) begin
      hs = hs + SLOTS;
    end
    hbyte = (s1_col < w_eff) ? mem_q[SLOT_W'(hs)] : '0;
  end

  always_ff @(posedge clk) begin
    if (en && s1_ctl.valid) begin
      vline[0] <= mem_q;
      hline[0] <= hbyte;
      for (int k = 1; k < MAX_RADIUS; k++) begin
        vline[k] <= vline[k-1];
      end
      for (int k = 1; k < 2 * MAX_RADIUS; k++) begin
        hline[k] <= hline[k-1];
      end
    end
  end

  // Window values: vertical arm from buffered rows, the center, then the row arm.
  always_comb begin
    logic [SLOTS-1:0][PW-1:0] vword;
    logic [PW-1:0]            htap [TAPS];
    int                       rad;
    int                       rr;
    int                       sl;
    rad   = int'(r_eff);
    vword = '0;
    for (int k = 0; k < MAX_RADIUS; k++) begin
      if (k == rad - 1) begin
        vword = vline[k];
      end
    end
    for (int t = 0; t < TAPS; t++) begin
      if (t > int'(s1_col)) begin
        htap[t] = '0;
      end else if (t == 0) begin
        htap[t] = hbyte;
      end else begin
        htap[t] = hline[t-1];
      end
    end
    for (int p = 0; p < VN; p++) begin
      rr = int'(s1_row) - 2 * rad + p;
      sl = int'(s1_rslot) - 2 * rad + p;
      if (sl < 0) begin
        sl = sl + SLOTS;
      end
      if (p < 2 * rad) begin
        if ((rr >= 0) && (rr < int'(h_eff)) &&
            (int'(s1_col) - rad < int'(w_eff))) begin
          s1_vals[p] = vword[SLOT_W'(sl)];
        end else begin
          s1_vals[p] = '0;
        end
      end else if (p == 2 * rad) begin
        s1_vals[p] = s1_center;
      end else if (p <= 4 * rad + 1) begin
        s1_vals[p] = '0;
        for (int t = 0; t < TAPS; t++) begin
          if (t == 4 * rad + 1 - p) begin
            s1_vals[p] = htap[t];
          end
        end
      end else begin
        s1_vals[p] = '1;
      end
    end
  end

  cmf_rank_select #(
    .MAX_RADIUS (MAX_RADIUS)
  ) u_rank (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_ctl  (s1_ctl),
    .in_vals (s1_vals),
    .radius  (r_eff),
    .out_ctl (b_ctl),
    .median  (b_median)
  );

  assign new_res = en && b_ctl.valid && b_ctl.emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || medians.ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= new_res;
      end
    end else if (new_res) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || medians.ready) begin
      if (skid_valid) begin
        out_median    <= skid_median;
        out_frame_end <= skid_frame_end;
      end else begin
        out_median    <= b_median;
        out_frame_end <= b_ctl.frame_end;
      end
    end else if (new_res) begin
      skid_median    <= b_median;
      skid_frame_end <= b_ctl.frame_end;
    end
  end

  assign medians.valid        = out_valid;
  assign medians.median_value = out_median;
  assign medians.frame_end    = out_frame_end;

endmodule

// ===== rtl/core/cmf_checker.sv =====
// Port-level checker of the cross median filter and its binding.
`include "cross_median_filter_macros.svh"

module cmf_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [cmf_pkg::PIXEL_W-1:0] median_value,
  input logic                        frame_end
);

  `CMF_ASSERT_AFTER_RESET(a_quiet_after_reset, clk, rst, !out_valid)
  `CMF_ASSERT_SAME(a_hold_off_only_after_stall, clk, rst, !in_ready, $past(out_valid && !out_ready))
  `CMF_ASSERT_NEXT(a_stalled_word_holds, clk, rst, out_valid && !out_ready, out_valid && $stable(median_value) && $stable(frame_end))

endmodule

bind cross_median_filter cmf_checker u_cmf_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (pixels.ready),
  .out_valid    (medians.valid),
  .out_ready    (medians.ready),
  .median_value (medians.median_value),
  .frame_end    (medians.frame_end)
);

// ===== dv/cross_median_filter_tb.sv =====
// Self-checking testbench for the cross median filter: frames in, medians predicted and compared.
module cross_median_filter_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOT_COUNT = 2 * cmf_pkg::MAX_RADIUS;
  localparam int LINE_LEN   = cmf_pkg::MAX_WIDTH + cmf_pkg::MAX_RADIUS;
  localparam int TAP_COUNT  = 2 * cmf_pkg::MAX_RADIUS + 1;
  localparam int HEIGHT_CAP = 1023 - cmf_pkg::MAX_RADIUS;
  localparam int CYCLE_LIMIT = 2000000;
  localparam logic OP_IMAGE = ~cmf_pkg::OP_PAD;

  typedef struct packed {
    logic [cmf_pkg::PIXEL_W-1:0] median_value;
    logic                        frame_end;
  } median_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  cmf_cfg_if    cfg_bus ();
  cmf_pixel_if  pix_bus ();
  cmf_median_if med_bus ();

  cross_median_filter dut (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_bus),
    .pixels  (pix_bus),
    .medians (med_bus)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  logic [cmf_pkg::PIXEL_W-1:0] line_mem [SLOT_COUNT][LINE_LEN];
  logic [cmf_pkg::PIXEL_W-1:0] center_taps [TAP_COUNT];
  int unsigned        row_pos;
  int unsigned        col_pos;
  logic [9:0]         width_reg;
  logic [9:0]         height_reg;
  logic [2:0]         radius_reg;

  median_word_t pending_medians[$];
  int           error_count;
  int           items_sent;
  bit           calm;
  int unsigned  cycle_count;
  int           stall_left;

  function automatic int eff_width();
    if (width_reg == 0) return 1;
    return (width_reg > cmf_pkg::MAX_WIDTH) ? cmf_pkg::MAX_WIDTH : int'(width_reg);
  endfunction

  function automatic int eff_height();
    if (height_reg == 0) return 1;
    return (height_reg > HEIGHT_CAP) ? HEIGHT_CAP : int'(height_reg);
  endfunction

  function automatic int eff_radius();
    if (radius_reg == 0) return 1;
    return (radius_reg > cmf_pkg::MAX_RADIUS) ? cmf_pkg::MAX_RADIUS : int'(radius_reg);
  endfunction

  function automatic logic [cmf_pkg::PIXEL_W-1:0] line_read(int row, int col, int w, int h);
    if (row < 0 || row >= h || col < 0 || col >= w) return '0;
    return line_mem[row % SLOT_COUNT][col];
  endfunction

  function automatic void predict_median(logic op, logic [cmf_pkg::PIXEL_W-1:0] pix);
    int                          w, h, rad, r, c, i, j, k, m, n;
    logic [cmf_pkg::PIXEL_W-1:0] v;
    logic [cmf_pkg::PIXEL_W-1:0] vals [4*cmf_pkg::MAX_RADIUS+2];
    median_word_t                res;
    w = eff_width();
    h = eff_height();
    rad = eff_radius();
    r = int'(row_pos);
    c = int'(col_pos);
    n = 0;
    for (k = TAP_COUNT - 1; k > 0; k--) center_taps[k] = center_taps[k-1];
    center_taps[0] = (op == cmf_pkg::OP_PAD) ? '0 : pix;
    if (r >= rad && c >= rad) begin
      j = c - rad;
      i = r - rad;
      for (k = 0; k < 2 * rad; k++) begin
        vals[n] = line_read(r - 2 * rad + k, j, w, h);
        n++;
      end
      vals[n] = (r < h && j < w) ? center_taps[rad] : '0;
      n++;
      for (k = 0; k <= 2 * rad; k++) begin
        vals[n] = line_read(i, j - rad + k, w, h);
        n++;
      end
      for (k = 1; k < n; k++) begin
        v = vals[k];
        m = k;
        while (m > 0 && vals[m-1] > v) begin
          vals[m] = vals[m-1];
          m--;
        end
        vals[m] = v;
      end
      res.median_value = vals[2 * rad];
      res.frame_end = (r == h + rad - 1 && c == w + rad - 1);
      pending_medians = {pending_medians, res};
    end
    if (c >= rad && c - rad < w) line_mem[r % SLOT_COUNT][c - rad] = center_taps[rad];
    col_pos++;
    if (col_pos >= w + rad) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h + rad) row_pos = 0;
  endfunction

  task automatic send_pixel(logic op, logic [cmf_pkg::PIXEL_W-1:0] pix);
    if (!calm && $urandom_range(0, 9) == 0) begin
      pix_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    pix_bus.valid     <= 1'b1;
    pix_bus.operation <= op;
    pix_bus.pixel     <= pix;
    do @(posedge clk); while (!pix_bus.ready);
    predict_median(op, pix);
    items_sent++;
  endtask

  task automatic write_reg(logic [cmf_pkg::CFG_INDEX_W-1:0] idx,
                           logic [cmf_pkg::CFG_DATA_W-1:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    do @(posedge clk); while (!cfg_bus.ready);
    if (idx == cmf_pkg::IDX_WIDTH) width_reg = data;
    else if (idx == cmf_pkg::IDX_HEIGHT) height_reg = data;
    else if (idx == cmf_pkg::IDX_RADIUS) radius_reg = data[2:0];
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    pix_bus.valid <= 1'b0;
    while (pending_medians.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic configure(int w, int h, int rad);
    drain();
    write_reg(cmf_pkg::IDX_WIDTH, cmf_pkg::CFG_DATA_W'(w));
    write_reg(cmf_pkg::IDX_HEIGHT, cmf_pkg::CFG_DATA_W'(h));
    write_reg(cmf_pkg::IDX_RADIUS, cmf_pkg::CFG_DATA_W'(rad));
  endtask

  // Pixel style 0 is uniform random, 1 takes only the extremes 0 and 255.
  task automatic send_frame(int pixel_style);
    int                          rows, cols, r, c, w, h;
    logic                        op;
    logic [cmf_pkg::PIXEL_W-1:0] pix;
    w = eff_width();
    h = eff_height();
    rows = h + eff_radius();
    cols = w + eff_radius();
    for (r = 0; r < rows; r++) begin
      for (c = 0; c < cols; c++) begin
        pix = (pixel_style == 1) ? ($urandom_range(0, 1) ? 8'hFF : 8'h00)
                                 : cmf_pkg::PIXEL_W'($urandom_range(0, 255));
        if (r < h && c < w) op = ($urandom_range(0, 15) == 0) ? cmf_pkg::OP_PAD : OP_IMAGE;
        else op = ($urandom_range(0, 7) == 0) ? OP_IMAGE : cmf_pkg::OP_PAD;
        send_pixel(op, pix);
      end
    end
  endtask

  task automatic test_smallest_frames();
    configure(1, 1, 1);
    send_frame(1);
    send_frame(0);
    configure(0, 0, 0);
    send_frame(0);
    configure(3, 2, 7);
    send_frame(1);
  endtask

  task automatic test_widest_row();
    configure(1023, 1, 1);
    send_frame(0);
  endtask

  task automatic test_tallest_column();
    configure(1, 20, 2);
    send_frame(0);
  endtask

  task automatic test_random_frames();
    int target;
    target = items_sent + 100;
    while (items_sent < target) begin
      configure($urandom_range(1, 14), $urandom_range(1, 10), $urandom_range(0, 7));
      send_frame($urandom_range(0, 3) == 0);
    end
  endtask

  task automatic test_full_rate();
    drain();
    calm = 1'b1;
    repeat (2) begin
      configure($urandom_range(1, 16), $urandom_range(1, 8), $urandom_range(1, 5));
      send_frame(0);
    end
  endtask

  always @(posedge clk) begin
    median_word_t exp_word;
    if (!rst && med_bus.valid && med_bus.ready) begin
      if (pending_medians.size() == 0) begin
        $error("median result with nothing expected: %0d", med_bus.median_value);
        error_count++;
      end else begin
        exp_word = pending_medians.pop_front();
        if (med_bus.median_value !== exp_word.median_value) begin
          $error("median_value expected %0d actual %0d",
                 exp_word.median_value, med_bus.median_value);
          error_count++;
        end
        if (med_bus.frame_end !== exp_word.frame_end) begin
          $error("frame_end expected %0d actual %0d", exp_word.frame_end, med_bus.frame_end);
          error_count++;
        end
      end
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      med_bus.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 15);
      med_bus.ready <= 1'b0;
    end else begin
      med_bus.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    cfg_bus.valid = 1'b0;
    cfg_bus.index = cmf_pkg::IDX_WIDTH;
    cfg_bus.data  = '0;
    pix_bus.valid = 1'b0;
    pix_bus.operation = OP_IMAGE;
    pix_bus.pixel = '0;
    med_bus.ready = 1'b0;
    cycle_count = 0;
    stall_left = 0;
    error_count = 0;
    items_sent = 0;
    calm = 1'b0;
    row_pos = 0;
    col_pos = 0;
    width_reg = cmf_pkg::RESET_WIDTH;
    height_reg = cmf_pkg::RESET_HEIGHT;
    radius_reg = cmf_pkg::RESET_RADIUS;
    foreach (line_mem[s, x]) line_mem[s][x] = '0;
    foreach (center_taps[t]) center_taps[t] = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_smallest_frames();
    test_widest_row();
    test_tallest_column();
    test_random_frames();
    test_full_rate();
    drain();
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/cmf_pkg.sv
rtl/core/cmf_if.sv
rtl/core/cmf_rank_select.sv
rtl/core/cross_median_filter.sv
rtl/core/cmf_checker.sv
dv/cross_median_filter_tb.sv
